@@ hw/rtl/active_note_table_assert.svh @@
// Assertion macros for the active note table.
`ifndef ACTIVE_NOTE_TABLE_ASSERT_SVH
`define ACTIVE_NOTE_TABLE_ASSERT_SVH

// Checked only outside reset.
`define ANT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define ANT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/ant_pkg.sv @@
package ant_pkg;

   localparam int MAX_NOTES_DEF = 32;
   localparam int ENTRY_W       = 21;
   localparam int PITCH_W       = 7;

   localparam logic [1:0] KIND_NOTE  = 2'd0;
   localparam logic [1:0] KIND_CLEAR = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   localparam logic [2:0] STATUS_ADDED     = 3'd0;
   localparam logic [2:0] STATUS_CLEARED   = 3'd1;
   localparam logic [2:0] STATUS_INVALID   = 3'd2;
   localparam logic [2:0] STATUS_FULL      = 3'd3;
   localparam logic [2:0] STATUS_READ_DONE = 3'd4;

   localparam logic CSR_RANGE_LOW  = 1'b0;
   localparam logic CSR_RANGE_HIGH = 1'b1;

   // pitch mod 12 via reciprocal multiply; exact for 0..127
   function automatic logic [3:0] pitch_class(input logic [PITCH_W-1:0] p);
      logic [13:0] prod;
      logic [3:0]  q;
      logic [7:0]  m;
      logic [7:0]  r;
      prod = 14'(p) * 14'd43;
      q    = prod[12:9];
      m    = 8'(q) * 8'd12;
      r    = 8'(p) - m;
      return r[3:0];
   endfunction

   function automatic logic [PITCH_W-1:0] clamp_pitch(input logic [PITCH_W-1:0] p,
                                                      input logic [PITCH_W-1:0] lo,
                                                      input logic [PITCH_W-1:0] hi);
      logic [PITCH_W-1:0] v;
      v = (p < hi) ? p : hi;
      return (v > lo) ? v : lo;
   endfunction

endpackage

@@ hw/rtl/active_note_table.sv @@
// Active note table: ordered list of held MIDI notes (original pitch,
// clamped pitch, velocity) in a single-port-write, single-port-read RAM.
// Request channel: start/busy; a request is taken at an edge with start
// high and busy low. Kinds: note event, remove all, read entry.
// Result channel: one result per request, shown for one cycle with
// rsp_strobe high; the receiver cannot stall and must take it.
// Note-on, remove-all, invalid, full, a read past the count and a
// note-off on an empty table give their result the cycle after the
// request, busy stays low. A read of a held entry goes through the RAM
// read and ST_READ, with busy high in ST_READ.
// A note-off walks the table through one pitch-class compare, one entry
// per cycle, compacting in place; busy is high for the whole scan.
// Throughput: one request at a time; the next is taken once busy is low.
// CSR channel: csr_ready is always high; index 0 range_low, 1 range_high.
// Write CSRs only while idle.
// Reset (synchronous): table emptied, range 0..127, no result pending.
// RAM contents are not cleared; only entries below the count are read.
`include "active_note_table_assert.svh"

module active_note_table #(
   parameter int MAX_NOTES = ant_pkg::MAX_NOTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_pitch,
   input  logic [7:0] req_velocity,
   input  logic [4:0] req_index,
   output logic       rsp_strobe,
   output logic [2:0] rsp_status,
   output logic [5:0] rsp_count,
   output logic [5:0] rsp_active_count,
   output logic       rsp_entry_valid,
   output logic [6:0] rsp_entry_original,
   output logic [6:0] rsp_entry_processed,
   output logic [6:0] rsp_entry_velocity,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [6:0] csr_data
);

   localparam int AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
   localparam int CW = $clog2(MAX_NOTES + 1);
   localparam int XW = CW + 6;
   localparam int PW = ant_pkg::PITCH_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [CW-1:0] wptr_ff, wptr_in;
   logic [CW-1:0] removed_ff, removed_in;
   logic [3:0]    class_ff, class_in;
   logic [PW-1:0] range_low_ff, range_high_ff;

   logic          strobe_ff, strobe_in;
   logic [2:0]    status_ff, status_in;
   logic [5:0]    rcount_ff, rcount_in;
   logic [5:0]    ractive_ff, ractive_in;
   logic          evalid_ff, evalid_in;
   logic [PW-1:0] eorig_ff, eorig_in;
   logic [PW-1:0] eproc_ff, eproc_in;
   logic [PW-1:0] evel_ff, evel_in;

   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic [ant_pkg::ENTRY_W-1:0] wr_data;
   logic [AW-1:0]               rd_addr;
   logic [ant_pkg::ENTRY_W-1:0] rd_data;

   logic          accept;
   logic          note_ok;
   logic [CW:0]   scan_next;
   logic [AW+4:0] idx_ext;
   logic [XW-1:0] xcount, xactive;

   logic          scanning;
   logic          off_start;
   logic          tally_ok;

   ant_note_ram #(.MAX_NOTES(MAX_NOTES)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign note_ok   = !req_pitch[7] && !req_velocity[7];
   assign scan_next = (CW+1)'(scan_ff) + (CW+1)'(1);
   assign idx_ext   = (AW+5)'(req_index);

   assign scanning  = (state_ff == ST_SCAN);
   assign off_start = accept && (req_kind == ant_pkg::KIND_NOTE) && note_ok &&
                      (req_velocity == 8'd0) && (count_ff != '0);
   assign tally_ok  = ((CW+1)'(wptr_ff) + (CW+1)'(removed_ff)) == (CW+1)'(scan_ff);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      scan_in    = scan_ff;
      wptr_in    = wptr_ff;
      removed_in = removed_ff;
      class_in   = class_ff;
      strobe_in  = 1'b0;
      status_in  = status_ff;
      rcount_in  = rcount_ff;
      evalid_in  = 1'b0;
      eorig_in   = '0;
      eproc_in   = '0;
      evel_in    = '0;
      wr_en      = 1'b0;
      wr_addr    = count_ff[AW-1:0];
      wr_data    = {req_pitch[PW-1:0],
                    ant_pkg::clamp_pitch(req_pitch[PW-1:0], range_low_ff, range_high_ff),
                    req_velocity[PW-1:0]};
      rd_addr    = '0;
      xcount     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               strobe_in = 1'b1;
               status_in = ant_pkg::STATUS_INVALID;
               case (req_kind)
                  ant_pkg::KIND_NOTE: begin
                     if (!note_ok) begin
                        status_in = ant_pkg::STATUS_INVALID;
                     end else if (req_velocity != 8'd0) begin
                        if (count_ff >= CW'(MAX_NOTES)) begin
                           status_in = ant_pkg::STATUS_FULL;
                        end else begin
                           wr_en     = 1'b1;
                           count_in  = count_ff + CW'(1);
                           status_in = ant_pkg::STATUS_ADDED;
                           xcount    = XW'(1);
                        end
                     end else begin
                        status_in = ant_pkg::STATUS_CLEARED;
                        if (count_ff != '0) begin
                           strobe_in  = 1'b0;
                           state_in   = ST_SCAN;
                           scan_in    = '0;
                           wptr_in    = '0;
                           removed_in = '0;
                           class_in   = ant_pkg::pitch_class(req_pitch[PW-1:0]);
                        end
                     end
                  end
                  ant_pkg::KIND_CLEAR: begin
                     status_in = ant_pkg::STATUS_CLEARED;
                     xcount    = XW'(count_ff);
                     count_in  = '0;
                  end
                  ant_pkg::KIND_READ: begin
                     status_in = ant_pkg::STATUS_READ_DONE;
                     if ((CW+5)'(req_index) < (CW+5)'(count_ff)) begin
                        strobe_in = 1'b0;
                        rd_addr   = idx_ext[AW-1:0];
                        state_in  = ST_READ;
                     end
                  end
                  default: begin
                     status_in = ant_pkg::STATUS_INVALID;
                  end
               endcase
               rcount_in = xcount[5:0];
            end
         end
         ST_SCAN: begin
            wr_addr = wptr_ff[AW-1:0];
            wr_data = rd_data;
            if (ant_pkg::pitch_class(rd_data[ant_pkg::ENTRY_W-1 -: PW]) == class_ff) begin
               removed_in = removed_ff + CW'(1);
            end else begin
               wr_en   = 1'b1;
               wptr_in = wptr_ff + CW'(1);
            end
            if (scan_next < (CW+1)'(count_ff)) begin
               scan_in = scan_next[CW-1:0];
               rd_addr = scan_next[AW-1:0];
            end else begin
               state_in  = ST_IDLE;
               count_in  = wptr_in;
               strobe_in = 1'b1;
               status_in = ant_pkg::STATUS_CLEARED;
               xcount    = XW'(removed_in);
               rcount_in = xcount[5:0];
            end
         end
         ST_READ: begin
            state_in  = ST_IDLE;
            strobe_in = 1'b1;
            status_in = ant_pkg::STATUS_READ_DONE;
            rcount_in = '0;
            evalid_in = 1'b1;
            eorig_in  = rd_data[ant_pkg::ENTRY_W-1 -: PW];
            eproc_in  = rd_data[2*PW-1 -: PW];
            evel_in   = rd_data[PW-1:0];
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      xactive    = XW'(count_in);
      ractive_in = xactive[5:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         strobe_ff     <= 1'b0;
         range_low_ff  <= '0;
         range_high_ff <= '1;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ant_pkg::CSR_RANGE_LOW:  range_low_ff  <= csr_data;
               ant_pkg::CSR_RANGE_HIGH: range_high_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff    <= scan_in;
      wptr_ff    <= wptr_in;
      removed_ff <= removed_in;
      class_ff   <= class_in;
      status_ff  <= status_in;
      rcount_ff  <= rcount_in;
      ractive_ff <= ractive_in;
      evalid_ff  <= evalid_in;
      eorig_ff   <= eorig_in;
      eproc_ff   <= eproc_in;
      evel_ff    <= evel_in;
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_status          = status_ff;
   assign rsp_count           = rcount_ff;
   assign rsp_active_count    = ractive_ff;
   assign rsp_entry_valid     = evalid_ff;
   assign rsp_entry_original  = eorig_ff;
   assign rsp_entry_processed = eproc_ff;
   assign rsp_entry_velocity  = evel_ff;

   `ANT_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(MAX_NOTES), "count above table size")
   `ANT_ASSERT(a_strobe_idle, clock, reset, rsp_strobe |-> !busy, "result while busy")
   `ANT_ASSERT(a_wptr_behind, clock, reset, scanning |-> wptr_ff <= scan_ff, "wptr ahead of scan")
   `ANT_ASSERT(a_scan_sum, clock, reset, scanning |-> tally_ok, "kept plus removed differs from scanned")
   `ANT_ASSERT(a_off_busy, clock, reset, off_start |=> busy, "note-off scan did not start")

endmodule

@@ hw/rtl/ant_note_ram.sv @@
module ant_note_ram #(
   parameter int MAX_NOTES = ant_pkg::MAX_NOTES_DEF,
   localparam int AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [ant_pkg::ENTRY_W-1:0] wr_data,
   input  logic [AW-1:0]               rd_addr,
   output logic [ant_pkg::ENTRY_W-1:0] rd_data
);

   logic [ant_pkg::ENTRY_W-1:0] mem [MAX_NOTES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ tb/ant_tb_pkg.sv @@
package ant_tb_pkg;
   import ant_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int         TABLE_DEPTH = MAX_NOTES_DEF;

   typedef struct packed {
      logic [2:0] status;
      logic [5:0] count;
      logic [5:0] active_count;
      logic       entry_valid;
      logic [6:0] entry_original;
      logic [6:0] entry_processed;
      logic [6:0] entry_velocity;
   } note_result_type;

   class note_table_scoreboard;
      logic [6:0]      orig_pitch[TABLE_DEPTH];
      logic [6:0]      clamped_pitch[TABLE_DEPTH];
      logic [6:0]      note_velocity[TABLE_DEPTH];
      int unsigned     held;
      logic [6:0]      range_lo;
      logic [6:0]      range_hi;
      note_result_type expected_q[$];
      int unsigned     errors;
      int unsigned     checked;
      int unsigned     requests;
      int unsigned     adds;
      int unsigned     full_hits;
      int unsigned     note_offs;
      int unsigned     valid_reads;
      int unsigned     range_settings;

      function new();
         held           = 0;
         range_lo       = 7'd0;
         range_hi       = 7'd127;
         errors         = 0;
         checked        = 0;
         requests       = 0;
         adds           = 0;
         full_hits      = 0;
         note_offs      = 0;
         valid_reads    = 0;
         range_settings = 0;
      endfunction

      function void set_range(logic csr, logic [6:0] value);
         if (csr == CSR_RANGE_LOW) begin
            range_lo = value;
         end else begin
            range_hi = value;
            range_settings++;
         end
      endfunction

      function logic [6:0] clamp_to_range(logic [6:0] p);
         logic [6:0] v;
         v = (p < range_hi) ? p : range_hi;
         return (v > range_lo) ? v : range_lo;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // updates the table for one accepted request and queues its result
      function void note_request(logic [1:0] kind, logic [7:0] pitch,
                                 logic [7:0] vel, logic [4:0] idx);
         note_result_type r;
         int unsigned     keep;
         logic [3:0]      cls;
         r        = '0;
         r.status = STATUS_INVALID;
         requests++;
         case (kind)
            KIND_NOTE: begin
               if (pitch > 8'd127 || vel > 8'd127) begin
                  r.status = STATUS_INVALID;
               end else if (vel != 8'd0) begin
                  if (held >= TABLE_DEPTH) begin
                     r.status = STATUS_FULL;
                     full_hits++;
                  end else begin
                     orig_pitch[held]    = pitch[6:0];
                     clamped_pitch[held] = clamp_to_range(pitch[6:0]);
                     note_velocity[held] = vel[6:0];
                     held++;
                     r.status = STATUS_ADDED;
                     r.count  = 6'd1;
                     adds++;
                  end
               end else begin
                  cls  = 4'(pitch % 12);
                  keep = 0;
                  for (int i = 0; i < held; i++) begin
                     if (4'(orig_pitch[i] % 12) == cls) begin
                        r.count++;
                     end else begin
                        orig_pitch[keep]    = orig_pitch[i];
                        clamped_pitch[keep] = clamped_pitch[i];
                        note_velocity[keep] = note_velocity[i];
                        keep++;
                     end
                  end
                  held     = keep;
                  r.status = STATUS_CLEARED;
                  note_offs++;
               end
            end
            KIND_CLEAR: begin
               r.count  = 6'(held);
               held     = 0;
               r.status = STATUS_CLEARED;
            end
            KIND_READ: begin
               r.status = STATUS_READ_DONE;
               if (idx < held) begin
                  r.entry_valid     = 1'b1;
                  r.entry_original  = orig_pitch[idx];
                  r.entry_processed = clamped_pitch[idx];
                  r.entry_velocity  = note_velocity[idx];
                  valid_reads++;
               end
            end
            default: r.status = STATUS_INVALID;
         endcase
         r.active_count = 6'(held);
         expected_q = {expected_q, r};
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(note_result_type got);
         note_result_type want;
         if (expected_q.size() == 0) begin
            $error("result with no request outstanding, status %0d", got.status);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("count", want.count, got.count);
         compare_field("active_count", want.active_count, got.active_count);
         compare_field("entry_valid", want.entry_valid, got.entry_valid);
         compare_field("entry_original", want.entry_original, got.entry_original);
         compare_field("entry_processed", want.entry_processed, got.entry_processed);
         compare_field("entry_velocity", want.entry_velocity, got.entry_velocity);
         checked++;
      endfunction
   endclass

endpackage

@@ tb/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ant_pkg::*;
   import ant_tb_pkg::*;

   localparam int QUIET_LIMIT = 1000;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 105;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [1:0] req_kind = KIND_NOTE;
   logic [7:0] req_pitch = 8'd0;
   logic [7:0] req_velocity = 8'd0;
   logic [4:0] req_index = 5'd0;
   logic       rsp_strobe;
   logic [2:0] rsp_status;
   logic [5:0] rsp_count;
   logic [5:0] rsp_active_count;
   logic       rsp_entry_valid;
   logic [6:0] rsp_entry_original;
   logic [6:0] rsp_entry_processed;
   logic [6:0] rsp_entry_velocity;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = CSR_RANGE_LOW;
   logic [6:0] csr_data = 7'd0;

   note_table_scoreboard sb = new();
   int unsigned burst_left;
   int unsigned quiet_cycles = 0;

   active_note_table u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_kind            (req_kind),
      .req_pitch           (req_pitch),
      .req_velocity        (req_velocity),
      .req_index           (req_index),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_count           (rsp_count),
      .rsp_active_count    (rsp_active_count),
      .rsp_entry_valid     (rsp_entry_valid),
      .rsp_entry_original  (rsp_entry_original),
      .rsp_entry_processed (rsp_entry_processed),
      .rsp_entry_velocity  (rsp_entry_velocity),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      note_result_type got;
      if (!reset && rsp_strobe) begin
         got.status          = rsp_status;
         got.count           = rsp_count;
         got.active_count    = rsp_active_count;
         got.entry_valid     = rsp_entry_valid;
         got.entry_original  = rsp_entry_original;
         got.entry_processed = rsp_entry_processed;
         got.entry_velocity  = rsp_entry_velocity;
         sb.check_result(got);
      end
   end

   // watchdog: no request, result or csr write for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic issue_request(input logic [1:0] kind, input logic [7:0] pitch,
                                input logic [7:0] vel, input logic [4:0] idx);
      int unsigned gap;
      start        <= 1'b1;
      req_kind     <= kind;
      req_pitch    <= pitch;
      req_velocity <= vel;
      req_index    <= idx;
      do @(posedge clock); while (busy);
      sb.note_request(kind, pitch, vel, idx);
      burst_left--;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                  : $urandom_range(1, 12);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_pitch_range(input logic [6:0] lo, input logic [6:0] hi);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= CSR_RANGE_LOW;
      csr_data  <= lo;
      do @(posedge clock); while (!csr_ready);
      sb.set_range(CSR_RANGE_LOW, lo);
      csr_index <= CSR_RANGE_HIGH;
      csr_data  <= hi;
      do @(posedge clock); while (!csr_ready);
      sb.set_range(CSR_RANGE_HIGH, hi);
      csr_valid <= 1'b0;
   endtask

   // filling phases lean hard on note-ons so the table runs full
   task automatic random_request(input bit filling);
      int unsigned r;
      int unsigned cls;
      int unsigned on_w;
      int unsigned off_w;
      int unsigned bad_w;
      int unsigned unused_w;
      int unsigned clr_w;
      logic [1:0]  kind;
      logic [7:0]  pitch;
      logic [7:0]  vel;
      logic [4:0]  idx;
      kind     = KIND_NOTE;
      pitch    = 8'($urandom_range(0, 127));
      vel      = 8'($urandom_range(1, 127));
      idx      = 5'($urandom_range(0, 31));
      on_w     = filling ? 75 : 45;
      off_w    = on_w + (filling ? 8 : 15);
      bad_w    = off_w + 5;
      unused_w = bad_w + 3;
      clr_w    = unused_w + (filling ? 1 : 4);
      r        = $urandom_range(0, 99);
      if (r < on_w) begin
         kind = KIND_NOTE;
      end else if (r < off_w) begin
         vel = 8'd0;
         if (sb.held != 0 && $urandom_range(0, 2) != 0) begin
            cls   = sb.orig_pitch[$urandom_range(0, sb.held - 1)] % 12;
            pitch = 8'(cls + 12 * $urandom_range(0, (127 - cls) / 12));
         end
      end else if (r < bad_w) begin
         if ($urandom_range(0, 1) != 0) begin
            pitch = 8'($urandom_range(128, 255));
            vel   = 8'($urandom_range(0, 255));
         end else begin
            vel = 8'($urandom_range(128, 255));
         end
      end else if (r < unused_w) begin
         kind  = KIND_UNUSED;
         pitch = 8'($urandom);
         vel   = 8'($urandom);
      end else if (r < clr_w) begin
         kind = KIND_CLEAR;
      end else begin
         kind = KIND_READ;
         if (sb.held != 0 && $urandom_range(0, 4) != 0) begin
            idx = 5'($urandom_range(0, sb.held - 1));
         end
      end
      issue_request(kind, pitch, vel, idx);
   endtask

   initial begin
      burst_left = $urandom_range(1, 12);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, extremes, invalid items, note-off matching
      issue_request(KIND_READ, 8'd0, 8'd0, 5'd0);
      issue_request(KIND_NOTE, 8'd40, 8'd0, 5'd0);
      issue_request(KIND_NOTE, 8'd0, 8'd1, 5'd0);
      issue_request(KIND_NOTE, 8'd127, 8'd127, 5'd31);
      issue_request(KIND_NOTE, 8'd128, 8'd64, 5'd0);
      issue_request(KIND_NOTE, 8'd255, 8'd255, 5'd0);
      issue_request(KIND_NOTE, 8'd60, 8'd128, 5'd0);
      issue_request(KIND_UNUSED, 8'd255, 8'd255, 5'd31);
      issue_request(KIND_READ, 8'd0, 8'd0, 5'd0);
      issue_request(KIND_READ, 8'd0, 8'd0, 5'd1);
      issue_request(KIND_READ, 8'd0, 8'd0, 5'd31);
      issue_request(KIND_NOTE, 8'd12, 8'd100, 5'd0);
      issue_request(KIND_NOTE, 8'd61, 8'd50, 5'd0);
      issue_request(KIND_NOTE, 8'd24, 8'd0, 5'd0);
      issue_request(KIND_READ, 8'd0, 8'd0, 5'd0);
      issue_request(KIND_NOTE, 8'd5, 8'd0, 5'd0);
      issue_request(KIND_CLEAR, 8'd0, 8'd0, 5'd0);
      issue_request(KIND_CLEAR, 8'd0, 8'd0, 5'd0);

      // crossed range: lower bound wins
      set_pitch_range(7'd100, 7'd20);
      issue_request(KIND_NOTE, 8'd10, 8'd1, 5'd0);
      issue_request(KIND_NOTE, 8'd110, 8'd2, 5'd0);
      issue_request(KIND_NOTE, 8'd50, 8'd3, 5'd0);
      issue_request(KIND_READ, 8'd0, 8'd0, 5'd1);
      issue_request(KIND_READ, 8'd0, 8'd0, 5'd2);

      set_pitch_range(7'd60, 7'd72);
      issue_request(KIND_NOTE, 8'd30, 8'd5, 5'd0);
      issue_request(KIND_NOTE, 8'd90, 8'd6, 5'd0);
      issue_request(KIND_READ, 8'd0, 8'd0, 5'd3);
      issue_request(KIND_READ, 8'd0, 8'd0, 5'd4);

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       set_pitch_range(7'd0, 7'd127);
            1:       set_pitch_range(7'd127, 7'd0);
            2:       set_pitch_range(7'd0, 7'd0);
            3:       set_pitch_range(7'd127, 7'd127);
            4:       set_pitch_range(7'd48, 7'd84);
            default: set_pitch_range(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
         endcase
         repeat (PHASE_ITEMS) random_request(ph[0]);
      end

      wait_drained();
      repeat (40) @(posedge clock);
      $display("Ran %0d requests: %0d adds, %0d full rejections, %0d note-offs, %0d hit reads",
               sb.requests, sb.adds, sb.full_hits, sb.note_offs, sb.valid_reads);
      $display("Pitch range set %0d times; %0d results checked, %0d mismatches",
               sb.range_settings, sb.checked, sb.errors);
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
